// ===== design/rsrd_pkg.sv =====
// rsrd_pkg: shared types, codes and constants of the rgbe scanline run-length decoder
`default_nettype none

package rsrd_pkg;

    // fixed field widths
    localparam int LINE_W_BITS   = 13;
    localparam int DEF_MAX_WIDTH = 4096;
    localparam int COLUMN_BITS   = 12;

    // exponent bias of the shared rgbe exponent
    localparam int EXP_BIAS = 128;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_WIDTH = 2'd1,
        STATUS_RUN   = 2'd2
    } status_t;

    // scanline parse phase
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_CODE,
        PH_FILL,
        PH_LITERAL
    } phase_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PUT,
        S_RD_G,
        S_RD_B,
        S_CONV,
        S_PUSH,
        S_DONE,
        S_ERR
    } seq_state_t;

    // one converted pixel
    typedef struct packed {
        logic [31:0] red;
        logic [31:0] green;
        logic [31:0] blue;
    } pixel_t;

endpackage

`default_nettype wire

// ===== design/rsrd_scale.sv =====
// rsrd_scale: one rgbe mantissa and exponent to ieee single bits, with double rounding
`default_nettype none

module rsrd_scale (
    input  logic [7:0]  mant,
    input  logic [7:0]  expo,
    output logic [31:0] bits
);
    import rsrd_pkg::*;

    logic [39:0]        rep;
    logic [2:0]         lead;
    logic               rnd;
    logic [23:0]        sig;
    logic signed [10:0] bexp;
    logic signed [10:0] expsum;
    logic [3:0]         shift;
    logic [23:0]        shifted;
    logic [23:0]        mask;
    logic               guard;
    logic               sticky;

    // m/255 is the 8-bit pattern of m repeated; round to 24 bits, sticky is always set
    always_comb
    begin
        rep     = {5{mant}};
        lead    = 3'd0;
        rnd     = 1'b0;
        sig     = 24'd0;
        bexp    = 11'sd0;
        expsum  = 11'sd0;
        shift   = 4'd0;
        shifted = 24'd0;
        mask    = 24'd0;
        guard   = 1'b0;
        sticky  = 1'b0;
        bits    = 32'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (mant[i])
            begin
                lead = 3'(i);
            end
        end
        if (mant == 8'hFF)
        begin
            sig  = 24'h800000;
            bexp = 11'sd127;
        end
        else
        begin
            sig  = rep[6'(lead) + 6'd9 +: 24];
            rnd  = rep[6'(lead) + 6'd8];
            sig  = sig + 24'(rnd);
            bexp = 11'sd119 + $signed({8'd0, lead});
        end
        expsum = bexp + $signed({3'd0, expo}) - 11'(EXP_BIAS);
        if (mant == 8'd0)
        begin
            bits = 32'd0;
        end
        else if (expsum > 11'sd0)
        begin
            bits = {1'b0, expsum[7:0], sig[22:0]};
        end
        else
        begin
            // subnormal product, round to nearest even
            shift   = 4'(11'sd1 - expsum);
            shifted = sig >> shift;
            guard   = sig[shift - 4'd1];
            mask    = (24'd1 << (shift - 4'd1)) - 24'd1;
            sticky  = |(sig & mask);
            bits    = 32'(shifted) + 32'(guard && (sticky || shifted[0]));
        end
    end

endmodule

`default_nettype wire

// ===== design/rgbe_scanline_rle_decoder.sv =====
// rgbe_scanline_rle_decoder: top level, run-length scanline decoder with plane memory
//
//  channel   | signals                      | transfer when
//  ----------+------------------------------+-----------------------------
//  input     | in_valid/in_ready            | stream_byte, both high
//  output    | out_valid/out_ready          | one or two pixels or error, both high
//  config    | cfg_wr_en/cfg_wr_data        | line width, enable high
//
// A header or code byte is taken in the idle state; a plane byte adds put, with one
// write per column, and done. An exponent byte adds put, RD_G, RD_B, CONV per pixel
// and PUSH per result, as R, G and B share the single read port of the plane memory.
// Reset clears control state only; the plane memory has no clearing pass.
// A stalled output holds the sequencer in its push state; an error halts until reset.
`default_nettype none

module rgbe_scanline_rle_decoder #(
    parameter int MAX_WIDTH = rsrd_pkg::DEF_MAX_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    stream_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [31:0]                   first_red,
    output logic [31:0]                   first_green,
    output logic [31:0]                   first_blue,
    output logic [31:0]                   second_red,
    output logic [31:0]                   second_green,
    output logic [31:0]                   second_blue,
    output logic [1:0]                    pixel_count,
    output logic [rsrd_pkg::COLUMN_BITS-1:0] first_column,
    output logic                          line_done,
    output logic                          run_last,
    output logic [1:0]                    status,
    input  logic                          cfg_wr_en,
    input  logic [rsrd_pkg::LINE_W_BITS-1:0] cfg_wr_data
);
    import rsrd_pkg::*;

    localparam int DEPTH  = 3 * MAX_WIDTH;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_W  = $clog2(4 * MAX_WIDTH + 1);
    localparam int CIDX_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W  = ((COL_W > LINE_W_BITS + 2) ? COL_W : LINE_W_BITS + 2) + 1;

    // control state
    seq_state_t               state_reg, state_next;
    phase_t                   phase_reg, phase_next;
    logic [1:0]               hdr_idx_reg, hdr_idx_next;
    logic [7:0]               hdr_high_reg, hdr_high_next;
    logic [COL_W-1:0]         column_reg, column_next;
    logic [7:0]               lit_rem_reg, lit_rem_next;
    logic [6:0]               fill_len_reg, fill_len_next;
    logic                     halted_reg, halted_next;
    logic [LINE_W_BITS-1:0]   line_width_reg;
    logic [6:0]               cnt_reg, cnt_next;
    logic [1:0]               pair_cnt_reg, pair_cnt_next;
    logic                     out_valid_reg, out_valid_next;

    // payload state
    logic [7:0]               byte_reg, byte_next;
    logic [CIDX_W-1:0]        col_reg, col_next;
    logic [7:0]               red_m_reg, red_m_next;
    logic [7:0]               green_m_reg, green_m_next;
    logic [7:0]               rd_data_reg;
    status_t                  err_reg, err_next;
    pixel_t                   first_pix_reg, first_pix_next;
    pixel_t                   second_pix_reg, second_pix_next;
    logic [COLUMN_BITS-1:0]   pair_col_reg, pair_col_next;
    logic                     pair_done_reg, pair_done_next;
    logic                     last_reg, last_next;
    pixel_t                   out_first_reg, out_first_next;
    pixel_t                   out_second_reg, out_second_next;
    logic [1:0]               out_count_reg, out_count_next;
    logic [COLUMN_BITS-1:0]   out_col_reg, out_col_next;
    logic                     out_done_reg, out_done_next;
    logic                     out_last_reg, out_last_next;
    status_t                  out_status_reg, out_status_next;

    // plane memory
    logic [7:0]               plane_mem [DEPTH];
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [ADDR_W-1:0]        mem_raddr;

    // datapath helpers
    logic                     in_fire;
    logic                     out_free;
    logic                     width_ok;
    logic [15:0]              hdr_width;
    logic [CMP_W-1:0]         w_ext;
    logic [CMP_W-1:0]         lim3;
    logic [CMP_W-1:0]         lim4;
    logic [CMP_W-1:0]         col_ext;
    logic [CMP_W-1:0]         e_col;
    logic                     is_last_col;
    pixel_t                   conv_pix;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign width_ok  = (line_width_reg != '0) &&
                       ({16'd0, line_width_reg} <= (16 + LINE_W_BITS)'(MAX_WIDTH));
    assign hdr_width = {hdr_high_reg, stream_byte};
    assign w_ext     = CMP_W'(line_width_reg);
    assign lim3      = (w_ext << 1) + w_ext;
    assign lim4      = w_ext << 2;
    assign col_ext   = CMP_W'(column_reg);
    assign e_col     = col_ext - lim3;
    assign is_last_col = (CMP_W'(col_reg) + CMP_W'(1)) == w_ext;
    assign mem_waddr = ADDR_W'(column_reg);

    // three channel converters share the exponent byte
    rsrd_scale u_scale_r (.mant(red_m_reg),   .expo(byte_reg), .bits(conv_pix.red));
    rsrd_scale u_scale_g (.mant(green_m_reg), .expo(byte_reg), .bits(conv_pix.green));
    rsrd_scale u_scale_b (.mant(rd_data_reg), .expo(byte_reg), .bits(conv_pix.blue));

    // sequencer next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        hdr_idx_next    = hdr_idx_reg;
        hdr_high_next   = hdr_high_reg;
        column_next     = column_reg;
        lit_rem_next    = lit_rem_reg;
        fill_len_next   = fill_len_reg;
        halted_next     = halted_reg;
        cnt_next        = cnt_reg;
        pair_cnt_next   = pair_cnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        byte_next       = byte_reg;
        col_next        = col_reg;
        red_m_next      = red_m_reg;
        green_m_next    = green_m_reg;
        err_next        = err_reg;
        first_pix_next  = first_pix_reg;
        second_pix_next = second_pix_reg;
        pair_col_next   = pair_col_reg;
        pair_done_next  = pair_done_reg;
        last_next       = last_reg;
        out_first_next  = out_first_reg;
        out_second_next = out_second_reg;
        out_count_next  = out_count_reg;
        out_col_next    = out_col_reg;
        out_done_next   = out_done_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_raddr       = ADDR_W'(e_col);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && !halted_reg)
                begin
                    unique case (phase_reg)
                        PH_HEADER:
                        begin
                            if (hdr_idx_reg == 2'd3)
                            begin
                                hdr_idx_next = 2'd0;
                                if (!width_ok || hdr_width != {3'd0, line_width_reg})
                                begin
                                    err_next   = STATUS_WIDTH;
                                    state_next = S_ERR;
                                end
                                else
                                begin
                                    column_next = '0;
                                    phase_next  = PH_CODE;
                                end
                            end
                            else
                            begin
                                if (hdr_idx_reg == 2'd2)
                                begin
                                    hdr_high_next = stream_byte;
                                end
                                hdr_idx_next = hdr_idx_reg + 2'd1;
                            end
                        end
                        PH_CODE:
                        begin
                            if (!width_ok)
                            begin
                                err_next   = STATUS_RUN;
                                state_next = S_ERR;
                            end
                            else if (stream_byte[7] && stream_byte[6:0] != 7'd0)
                            begin
                                if (col_ext + CMP_W'(stream_byte[6:0]) > lim4)
                                begin
                                    err_next   = STATUS_RUN;
                                    state_next = S_ERR;
                                end
                                else
                                begin
                                    fill_len_next = stream_byte[6:0];
                                    phase_next    = PH_FILL;
                                end
                            end
                            else if (stream_byte == 8'd0 ||
                                     col_ext + CMP_W'(stream_byte) > lim4)
                            begin
                                err_next   = STATUS_RUN;
                                state_next = S_ERR;
                            end
                            else
                            begin
                                lit_rem_next = stream_byte;
                                phase_next   = PH_LITERAL;
                            end
                        end
                        PH_FILL:
                        begin
                            if (!width_ok || col_ext + CMP_W'(fill_len_reg) > lim4)
                            begin
                                err_next   = STATUS_RUN;
                                state_next = S_ERR;
                            end
                            else
                            begin
                                byte_next     = stream_byte;
                                cnt_next      = fill_len_reg;
                                fill_len_next = 7'd0;
                                phase_next    = PH_CODE;
                                state_next    = S_PUT;
                            end
                        end
                        PH_LITERAL:
                        begin
                            if (!width_ok || col_ext >= lim4)
                            begin
                                err_next   = STATUS_RUN;
                                state_next = S_ERR;
                            end
                            else
                            begin
                                byte_next    = stream_byte;
                                cnt_next     = 7'd1;
                                lit_rem_next = lit_rem_reg - 8'(lit_rem_reg != 8'd0);
                                if (lit_rem_next == 8'd0)
                                begin
                                    phase_next = PH_CODE;
                                end
                                state_next = S_PUT;
                            end
                        end
                    endcase
                end
            end
            S_PUT:
            begin
                if (col_ext < lim3)
                begin
                    // color plane byte goes to memory
                    mem_we      = 1'b1;
                    column_next = column_reg + COL_W'(1);
                    cnt_next    = cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1)
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    // exponent byte, start red read
                    mem_raddr  = ADDR_W'(e_col);
                    col_next   = CIDX_W'(e_col);
                    state_next = S_RD_G;
                end
            end
            S_RD_G:
            begin
                mem_raddr  = ADDR_W'(CMP_W'(col_reg) + w_ext);
                red_m_next = rd_data_reg;
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                mem_raddr    = ADDR_W'(CMP_W'(col_reg) + (w_ext << 1));
                green_m_next = rd_data_reg;
                state_next   = S_CONV;
            end
            S_CONV:
            begin
                column_next = column_reg + COL_W'(1);
                cnt_next    = cnt_reg - 7'd1;
                if (pair_cnt_reg == 2'd0)
                begin
                    first_pix_next = conv_pix;
                    pair_col_next  = COLUMN_BITS'(col_reg);
                    pair_done_next = is_last_col;
                end
                else
                begin
                    second_pix_next = conv_pix;
                    pair_done_next  = pair_done_reg || is_last_col;
                end
                pair_cnt_next = pair_cnt_reg + 2'd1;
                if (pair_cnt_reg == 2'd1 || cnt_reg == 7'd1)
                begin
                    last_next  = (cnt_reg == 7'd1);
                    state_next = S_PUSH;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_PUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_first_next  = first_pix_reg;
                    out_second_next = (pair_cnt_reg == 2'd2) ? second_pix_reg : '0;
                    out_count_next  = pair_cnt_reg;
                    out_col_next    = pair_col_reg;
                    out_done_next   = pair_done_reg;
                    out_last_next   = last_reg;
                    out_status_next = STATUS_OK;
                    pair_cnt_next   = 2'd0;
                    state_next      = last_reg ? S_DONE : S_PUT;
                end
            end
            S_DONE:
            begin
                // line end check after the byte
                if (col_ext >= lim4)
                begin
                    phase_next   = PH_HEADER;
                    hdr_idx_next = 2'd0;
                    column_next  = '0;
                end
                state_next = S_IDLE;
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_first_next  = '0;
                    out_second_next = '0;
                    out_count_next  = 2'd0;
                    out_col_next    = '0;
                    out_done_next   = 1'b0;
                    out_last_next   = 1'b1;
                    out_status_next = err_reg;
                    halted_next     = 1'b1;
                    state_next      = S_IDLE;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_HEADER;
            hdr_idx_reg    <= 2'd0;
            hdr_high_reg   <= 8'd0;
            column_reg     <= '0;
            lit_rem_reg    <= 8'd0;
            fill_len_reg   <= 7'd0;
            halted_reg     <= 1'b0;
            line_width_reg <= LINE_W_BITS'(1);
            cnt_reg        <= 7'd0;
            pair_cnt_reg   <= 2'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            hdr_idx_reg   <= hdr_idx_next;
            hdr_high_reg  <= hdr_high_next;
            column_reg    <= column_next;
            lit_rem_reg   <= lit_rem_next;
            fill_len_reg  <= fill_len_next;
            halted_reg    <= halted_next;
            cnt_reg       <= cnt_next;
            pair_cnt_reg  <= pair_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                line_width_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        col_reg        <= col_next;
        red_m_reg      <= red_m_next;
        green_m_reg    <= green_m_next;
        err_reg        <= err_next;
        first_pix_reg  <= first_pix_next;
        second_pix_reg <= second_pix_next;
        pair_col_reg   <= pair_col_next;
        pair_done_reg  <= pair_done_next;
        last_reg       <= last_next;
        out_first_reg  <= out_first_next;
        out_second_reg <= out_second_next;
        out_count_reg  <= out_count_next;
        out_col_reg    <= out_col_next;
        out_done_reg   <= out_done_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    // plane memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            plane_mem[mem_waddr] <= byte_reg;
        end
        rd_data_reg <= plane_mem[mem_raddr];
    end

    // output ports
    assign out_valid    = out_valid_reg;
    assign first_red    = out_first_reg.red;
    assign first_green  = out_first_reg.green;
    assign first_blue   = out_first_reg.blue;
    assign second_red   = out_second_reg.red;
    assign second_green = out_second_reg.green;
    assign second_blue  = out_second_reg.blue;
    assign pixel_count  = out_count_reg;
    assign first_column = out_col_reg;
    assign line_done    = out_done_reg;
    assign run_last     = out_last_reg;
    assign status       = out_status_reg;

endmodule

`default_nettype wire

// ===== design/rsrd_checker.sv =====
// rsrd_checker: port-level assertions on the decoder results, bound to the top level
`default_nettype none

module rsrd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [31:0]                   first_red,
    input logic [31:0]                   second_red,
    input logic [31:0]                   second_green,
    input logic [31:0]                   second_blue,
    input logic [1:0]                    pixel_count,
    input logic                          line_done,
    input logic                          run_last,
    input logic [1:0]                    status
);
    import rsrd_pkg::*;

    // stalled result holds its first red and its status
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(first_red) && $stable(status))
    else $error("result changed while stalled");

    // error result carries no pixels and closes the byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> pixel_count == 2'd0 && run_last)
    else $error("malformed error result");

    // single-pixel result has empty second slot
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_OK && pixel_count == 2'd1 |->
        second_red == 32'd0 && second_green == 32'd0 && second_blue == 32'd0)
    else $error("second pixel not cleared");

    // scanline end is the last result of its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_done |-> run_last && (pixel_count == 2'd1 || pixel_count == 2'd2))
    else $error("line end not on last result");

endmodule

bind rgbe_scanline_rle_decoder rsrd_checker u_rsrd_checker (.*);

`default_nettype wire
